### sv/paren_add_sub_expression_evaluator_defines.svh
// Assertion macros for the expression evaluator checker.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef PAREN_ADD_SUB_EXPRESSION_EVALUATOR_DEFINES_SVH
`define PAREN_ADD_SUB_EXPRESSION_EVALUATOR_DEFINES_SVH

// check cons in the same cycle as ante
`define PASE_CHK_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// check cons in the cycle after ante
`define PASE_CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/pase_pkg.sv
// Types, character codes and classification for the expression evaluator.
// No dependencies.
`default_nettype none
package pase_pkg;

	localparam int DATA_W     = 32;
	localparam int CHAR_W     = 8;
	localparam int STATUS_W   = 2;
	localparam int TDATA_IN_W = 8;
	localparam int TDATA_OUT_W = 40;

	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h28;
	localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h29;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK        = 2'd0,
		STATUS_OVERFLOW  = 2'd1,
		STATUS_UNMATCHED = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		KIND_DIGIT,
		KIND_PLUS,
		KIND_MINUS,
		KIND_OPEN,
		KIND_CLOSE,
		KIND_OTHER
	} kind_t;

	typedef struct packed {
		logic              fire;
		logic              last;
		logic [CHAR_W-1:0] ch;
	} step_t;

	typedef struct packed {
		status_t           status;
		logic [DATA_W-1:0] value;
	} result_t;

	function automatic kind_t classify(input logic [CHAR_W-1:0] ch);
		kind_t k;
		case (ch) inside
			[CH_ZERO:CH_NINE]: k = KIND_DIGIT;
			CH_PLUS:           k = KIND_PLUS;
			CH_MINUS:          k = KIND_MINUS;
			CH_OPEN:           k = KIND_OPEN;
			CH_CLOSE:          k = KIND_CLOSE;
			default:           k = KIND_OTHER;
		endcase
		return k;
	endfunction

endpackage
`default_nettype wire

### sv/pase_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module pase_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

### sv/pase_eval.sv
// Expression state and per-character update: running sum, number, sign, nesting stack.
// Depends on pase_pkg and pase_ram.
`default_nettype none
module pase_eval #(
	parameter int NEST_DEPTH = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pase_pkg::step_t   step,
	output pase_pkg::result_t      result
);
	import pase_pkg::*;

	localparam int AW = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
	localparam int LW = $clog2(NEST_DEPTH + 1);
	localparam int EW = DATA_W + 1;

	logic [DATA_W-1:0] sum_q, num_q, byp_sum_q;
	logic              neg_q, byp_neg_q, push_q;
	logic [LW-1:0]     level_q;
	status_t           err_q;

	logic [DATA_W-1:0] sum_d, num_d, term, inner_raw, inner, top_sum, fin_term;
	logic              neg_d, push, top_neg;
	logic [LW-1:0]     level_d, lvl_next, rd_lvl;
	status_t           err_d;
	kind_t             kind;
	logic [EW-1:0]     rd_data;
	logic [AW-1:0]     rd_addr;

	pase_ram #(
		.WIDTH(EW),
		.DEPTH(NEST_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (push),
		.waddr (level_q[AW-1:0]),
		.wdata ({neg_q, sum_q}),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	assign kind    = classify(step.ch);
	assign term    = neg_q ? (DATA_W'(0) - num_q) : num_q;
	assign top_sum = push_q ? byp_sum_q : rd_data[DATA_W-1:0];
	assign top_neg = push_q ? byp_neg_q : rd_data[DATA_W];
	assign inner_raw = sum_q + term;
	assign inner     = top_neg ? (DATA_W'(0) - inner_raw) : inner_raw;

	always_comb begin
		sum_d   = sum_q;
		num_d   = num_q;
		neg_d   = neg_q;
		level_d = level_q;
		err_d   = err_q;
		push    = 1'b0;
		if (step.fire) begin
			case (kind)
				KIND_DIGIT: begin
					num_d = (num_q << 3) + (num_q << 1)
						+ {{(DATA_W-CHAR_W){1'b0}}, step.ch - CH_ZERO};
				end
				KIND_PLUS, KIND_MINUS: begin
					sum_d = sum_q + term;
					num_d = '0;
					neg_d = (kind == KIND_MINUS);
				end
				KIND_OPEN: begin
					if (level_q != LW'(NEST_DEPTH)) begin
						push    = 1'b1;
						level_d = level_q + LW'(1);
						sum_d   = '0;
						neg_d   = 1'b0;
					end else if (err_q == STATUS_OK) begin
						err_d = STATUS_OVERFLOW;
					end
				end
				KIND_CLOSE: begin
					if (level_q != '0) begin
						sum_d   = top_sum + inner;
						num_d   = '0;
						level_d = level_q - LW'(1);
					end else if (err_q == STATUS_OK) begin
						err_d = STATUS_UNMATCHED;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign fin_term      = neg_d ? (DATA_W'(0) - num_d) : num_d;
	assign result.value  = (err_d == STATUS_OK) ? (sum_d + fin_term) : '0;
	assign result.status = err_d;

	assign lvl_next = (step.fire && step.last) ? '0 : level_d;
	assign rd_lvl   = lvl_next - LW'(1);
	assign rd_addr  = rd_lvl[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			num_q   <= '0;
			neg_q   <= 1'b0;
			level_q <= '0;
			err_q   <= STATUS_OK;
			push_q  <= 1'b0;
		end else begin
			push_q <= push;
			if (step.fire && step.last) begin
				sum_q   <= '0;
				num_q   <= '0;
				neg_q   <= 1'b0;
				level_q <= '0;
				err_q   <= STATUS_OK;
			end else begin
				sum_q   <= sum_d;
				num_q   <= num_d;
				neg_q   <= neg_d;
				level_q <= level_d;
				err_q   <= err_d;
			end
		end
	end

	// hold the word just pushed until the RAM read catches up
	always_ff @(posedge clk) begin
		if (push) begin
			byp_sum_q <= sum_q;
			byp_neg_q <= neg_q;
		end
	end

endmodule
`default_nettype wire

### sv/paren_add_sub_expression_evaluator.sv
// Expression evaluator for decimal integers with plus, minus and parentheses.
// Input channel s_*: one character per word; s_tlast marks the final character.
// Output channel m_*: one word per expression, value and status.
// A last character is held in the input register until processed; its result is then
// registered in the output word and shown until taken.
// Throughput: one character per cycle, but a last character waits while the result
// word is stalled; the running state and the nesting stack top update together, the
// stack RAM is written on push and read ahead of each pop.
// A stall on m_tready holds the result word; characters keep flowing until the next
// word that carries s_tlast reaches the input register, which then waits there with
// s_tready low until the result word is taken.
// Reset clears the running sum, the number, the sign, the nesting level and the
// status; the stack RAM needs no clearing, as an entry is read only after it is
// written in the same expression.
// Status: 0 ok, 1 nesting too deep, 2 unmatched close parenthesis; value is zero
// whenever status is not ok. All arithmetic wraps at 32 bits.
// Depends on pase_pkg, pase_eval and pase_ram.
`default_nettype none
module paren_add_sub_expression_evaluator #(
	parameter int NEST_DEPTH = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  s_tvalid,
	output logic                                       s_tready,
	input  wire logic [pase_pkg::TDATA_IN_W-1:0]       s_tdata,  // [7:0] char_code
	input  wire logic                                  s_tlast,  // is_last
	output logic                                       m_tvalid,
	input  wire logic                                  m_tready,
	output logic      [pase_pkg::TDATA_OUT_W-1:0]      m_tdata   // [31:0] value, [33:32] status
);
	import pase_pkg::*;

	logic              valid_s1, last_s1, fire;
	logic [CHAR_W-1:0] ch_s1;
	logic              out_valid_q;
	result_t           res_q, res;
	step_t             step;

	assign fire     = valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || fire;

	assign step.fire = fire;
	assign step.last = last_s1;
	assign step.ch   = ch_s1;

	pase_eval #(
		.NEST_DEPTH(NEST_DEPTH)
	) u_eval (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.result (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (fire && last_s1) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ch_s1   <= s_tdata[CHAR_W-1:0];
			last_s1 <= s_tlast;
		end
		if (fire && last_s1) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(TDATA_OUT_W-DATA_W-STATUS_W){1'b0}}, res_q.status, res_q.value};

endmodule
`default_nettype wire

### sv/pase_checker.sv
// Port-level checks for the expression evaluator, bound to the top level.
// Depends on paren_add_sub_expression_evaluator_defines.svh.
`default_nettype none
`include "paren_add_sub_expression_evaluator_defines.svh"
module pase_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [39:0] m_tdata
);

	`PASE_CHK_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result word changed while stalled")
	`PASE_CHK_NOW(a_pad_zero, m_tvalid, m_tdata[39:34] == 6'd0, "padding bits not zero")
	`PASE_CHK_NOW(a_status_code, m_tvalid, m_tdata[33:32] != 2'd3, "undefined status code")
	`PASE_CHK_NOW(a_err_value, m_tvalid && (m_tdata[33:32] != 2'd0), m_tdata[31:0] == 32'd0, "error result with nonzero value")

endmodule

bind paren_add_sub_expression_evaluator pase_checker u_pase_checker (.*);
`default_nettype wire
